// File: rtl/bpsu_pkg.sv
// Shared constants for the BMP pixel stream unpacker.
// Header byte positions, image size bounds and counter widths.
// No dependencies.
`timescale 1ns / 1ps

package bpsu_pkg;

  // Image size bounds
  localparam int unsigned MAX_WIDTH  = 4096;
  localparam int unsigned MAX_HEIGHT = 4096;

  // Header layout (little-endian 32-bit fields)
  localparam int unsigned POS_W      = 32;
  localparam int unsigned OFFSET_POS = 10;
  localparam int unsigned WIDTH_POS  = 18;
  localparam int unsigned HEIGHT_POS = 22;
  localparam int unsigned HEADER_END = 26;

  // Output index width
  localparam int unsigned IDX_W = 12;

  // Column/row counters must hold the bound itself and cover the output index
  localparam int unsigned COL_BITS = $clog2(MAX_WIDTH + 1);
  localparam int unsigned ROW_BITS = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned COL_W    = (COL_BITS > IDX_W) ? COL_BITS : IDX_W;
  localparam int unsigned ROW_W    = (ROW_BITS > IDX_W) ? ROW_BITS : IDX_W;

  typedef logic [POS_W-1:0] word_t;

endpackage

// File: rtl/bpsu_byte_if.sv
// Byte channel into the BMP pixel stream unpacker.
// Valid/ready handshake with the raw file byte and a start flag. No dependencies.
`timescale 1ns / 1ps

interface bpsu_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic       start_of_file;

  modport source (output valid, output byte_value, output start_of_file, input ready);
  modport sink   (input valid, input byte_value, input start_of_file, output ready);
endinterface

// File: rtl/bpsu_pix_if.sv
// Pixel channel out of the BMP pixel stream unpacker.
// Valid/ready handshake with one pixel or one header error per beat. No dependencies.
`timescale 1ns / 1ps

interface bpsu_pix_if;
  logic        valid;
  logic        ready;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic [11:0] pixel_row;
  logic [11:0] pixel_column;
  logic        last_pixel;
  logic        header_error;

  modport source (output valid, output red, output green, output blue,
                  output pixel_row, output pixel_column, output last_pixel,
                  output header_error, input ready);
  modport sink   (input valid, input red, input green, input blue,
                  input pixel_row, input pixel_column, input last_pixel,
                  input header_error, output ready);
endinterface

// File: rtl/bmp_pixel_stream_unpacker.sv
// BMP pixel stream unpacker: 24-bit BMP file in, one byte per beat; pixels out.
// A pixel or error beat appears in the cycle after the byte that completes it.
// Throughput: 1 byte per cycle; a waiting output beat does not block input while
// the sink takes it in the same cycle (ready = output register empty or draining).
// Reset (rst_ni low, async): all parse state clears; the first byte is file byte zero.
// Uses bpsu_pkg, bpsu_byte_if and bpsu_pix_if.
`timescale 1ns / 1ps

module bmp_pixel_stream_unpacker (
  input  logic           clk_i,
  input  logic           rst_ni,
  bpsu_byte_if.sink      byte_i,
  bpsu_pix_if.source     pix_o
);

  localparam int unsigned PW = bpsu_pkg::POS_W;
  localparam int unsigned CW = bpsu_pkg::COL_W;
  localparam int unsigned RW = bpsu_pkg::ROW_W;

  // Parse state
  bpsu_pkg::word_t pos_q, pos_d;
  bpsu_pkg::word_t offset_q, offset_d;
  bpsu_pkg::word_t width_q, width_d;
  bpsu_pkg::word_t height_q, height_d;
  logic [15:0]     held_q, held_d;
  logic [1:0]      comp_q, comp_d;
  logic [1:0]      pad_q, pad_d;
  logic [CW-1:0]   col_q, col_d;
  logic [RW-1:0]   row_q, row_d;
  logic            done_q, done_d;

  // Result register
  logic        out_valid_q, out_valid_d;
  logic [7:0]  red_q, red_d;
  logic [7:0]  green_q, green_d;
  logic [7:0]  blue_q, blue_d;
  logic [11:0] orow_q, orow_d;
  logic [11:0] ocol_q, ocol_d;
  logic        last_q, last_d;
  logic        err_q, err_d;

  logic            in_beat;
  logic            emit;
  bpsu_pkg::word_t pos_e, offset_e, width_e, height_e;
  logic [1:0]      comp_e, pad_e;
  logic [CW-1:0]   col_e, col_inc;
  logic [RW-1:0]   row_e, row_inc;
  logic            done_e;
  logic [7:0]      b;

  // Accept a byte whenever the result register is empty or draining this cycle.
  assign byte_i.ready = !out_valid_q || pix_o.ready;
  assign in_beat      = byte_i.valid && byte_i.ready;
  assign b            = byte_i.byte_value;

  // Start flag acts as a restart: work from cleared state for this beat.
  assign pos_e    = byte_i.start_of_file ? '0 : pos_q;
  assign offset_e = byte_i.start_of_file ? '0 : offset_q;
  assign width_e  = byte_i.start_of_file ? '0 : width_q;
  assign height_e = byte_i.start_of_file ? '0 : height_q;
  assign comp_e   = byte_i.start_of_file ? '0 : comp_q;
  assign pad_e    = byte_i.start_of_file ? '0 : pad_q;
  assign col_e    = byte_i.start_of_file ? '0 : col_q;
  assign row_e    = byte_i.start_of_file ? '0 : row_q;
  assign done_e   = byte_i.start_of_file ? 1'b0 : done_q;

  assign col_inc = col_e + CW'(1);
  assign row_inc = row_e + RW'(1);

  always_comb begin
    pos_d    = pos_q;
    offset_d = offset_q;
    width_d  = width_q;
    height_d = height_q;
    held_d   = held_q;
    comp_d   = comp_q;
    pad_d    = pad_q;
    col_d    = col_q;
    row_d    = row_q;
    done_d   = done_q;
    emit     = 1'b0;
    red_d    = red_q;
    green_d  = green_q;
    blue_d   = blue_q;
    orow_d   = orow_q;
    ocol_d   = ocol_q;
    last_d   = last_q;
    err_d    = err_q;

    if (in_beat) begin
      offset_d = offset_e;
      width_d  = width_e;
      height_d = height_e;
      comp_d   = comp_e;
      pad_d    = pad_e;
      col_d    = col_e;
      row_d    = row_e;
      done_d   = done_e;

      // Byte position saturates at all ones.
      pos_d = (pos_e == '1) ? pos_e : pos_e + PW'(1);

      if (done_e) begin
        // Image finished or rejected: drop bytes until the next start flag.
      end else if (pos_e < PW'(bpsu_pkg::HEADER_END)) begin
        // Drop each header byte into its lane of the matching field.
        for (int k = 0; k < 4; k++) begin
          if (pos_e == PW'(bpsu_pkg::OFFSET_POS + k)) offset_d[8*k +: 8] = b;
          if (pos_e == PW'(bpsu_pkg::WIDTH_POS + k))  width_d[8*k +: 8]  = b;
          if (pos_e == PW'(bpsu_pkg::HEIGHT_POS + k)) height_d[8*k +: 8] = b;
        end
        // Last header byte completes the height: check the whole header now.
        if (pos_e == PW'(bpsu_pkg::HEADER_END - 1)) begin
          if (width_d == '0 || width_d > PW'(bpsu_pkg::MAX_WIDTH) ||
              height_d == '0 || height_d > PW'(bpsu_pkg::MAX_HEIGHT) ||
              offset_d < PW'(bpsu_pkg::HEADER_END)) begin
            done_d  = 1'b1;
            emit    = 1'b1;
            red_d   = '0;
            green_d = '0;
            blue_d  = '0;
            orow_d  = '0;
            ocol_d  = '0;
            last_d  = 1'b0;
            err_d   = 1'b1;
          end
        end
      end else if (pos_e < offset_e) begin
        // Skip the gap between header and pixel data.
      end else if (pad_e != 2'd0) begin
        pad_d = pad_e - 2'd1;
      end else if (comp_e == 2'd0) begin
        held_d[7:0] = b;
        comp_d      = 2'd1;
      end else if (comp_e == 2'd1) begin
        held_d[15:8] = b;
        comp_d       = 2'd2;
      end else begin
        // Red byte closes the pixel.
        comp_d  = 2'd0;
        emit    = 1'b1;
        red_d   = b;
        green_d = held_q[15:8];
        blue_d  = held_q[7:0];
        orow_d  = row_e[11:0];
        ocol_d  = col_e[11:0];
        last_d  = 1'b0;
        err_d   = 1'b0;
        col_d   = col_inc;
        // Width is validated, so it fits the column counter.
        if (col_inc == width_e[CW-1:0]) begin
          col_d = '0;
          row_d = row_inc;
          // Row padding to four bytes equals width mod 4 for 3-byte pixels.
          pad_d = width_e[1:0];
          if (row_inc == height_e[RW-1:0]) begin
            last_d = 1'b1;
            done_d = 1'b1;
          end
        end
      end
    end

    // Hold the result until taken; a new beat may refill it in the same cycle.
    if (in_beat) begin
      out_valid_d = emit;
    end else if (pix_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      offset_q    <= '0;
      width_q     <= '0;
      height_q    <= '0;
      held_q      <= '0;
      comp_q      <= '0;
      pad_q       <= '0;
      col_q       <= '0;
      row_q       <= '0;
      done_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      pos_q       <= pos_d;
      offset_q    <= offset_d;
      width_q     <= width_d;
      height_q    <= height_d;
      held_q      <= held_d;
      comp_q      <= comp_d;
      pad_q       <= pad_d;
      col_q       <= col_d;
      row_q       <= row_d;
      done_q      <= done_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload: loaded only with a new result, no reset needed.
  always_ff @(posedge clk_i) begin
    if (in_beat && emit) begin
      red_q   <= red_d;
      green_q <= green_d;
      blue_q  <= blue_d;
      orow_q  <= orow_d;
      ocol_q  <= ocol_d;
      last_q  <= last_d;
      err_q   <= err_d;
    end
  end

  assign pix_o.valid        = out_valid_q;
  assign pix_o.red          = red_q;
  assign pix_o.green        = green_q;
  assign pix_o.blue         = blue_q;
  assign pix_o.pixel_row    = orow_q;
  assign pix_o.pixel_column = ocol_q;
  assign pix_o.last_pixel   = last_q;
  assign pix_o.header_error = err_q;

endmodule

// File: tb/bpsu_stream_checker.sv
// Scoreboard for the BMP pixel stream unpacker: watches both channels,
// predicts pixel and header-error beats from accepted bytes, compares them.
// Depends on bpsu_pkg, bpsu_byte_if and bpsu_pix_if.
`timescale 1ns / 1ps

module bpsu_stream_checker (
  input  logic  clk_i,
  input  logic  rst_ni,
  bpsu_byte_if  byte_if,
  bpsu_pix_if   pix_if,
  output int    fail_count_o,
  output int    pending_o
);
  import bpsu_pkg::*;

  typedef struct packed {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [11:0] row;
    logic [11:0] column;
    logic        last;
    logic        hdr_err;
  } pixel_beat_t;

  pixel_beat_t pending_pixels[$];
  int          mismatches;

  // Parser shadow state
  word_t      byte_pos;
  word_t      pix_offset;
  word_t      img_w;
  word_t      img_h;
  logic [7:0] held_blue;
  logic [7:0] held_green;
  logic [1:0] comp_cnt;
  logic [1:0] pad_left;
  word_t      col_idx;
  word_t      row_idx;
  logic       image_done;

  task automatic clear_parser();
    byte_pos   = '0;
    pix_offset = '0;
    img_w      = '0;
    img_h      = '0;
    held_blue  = '0;
    held_green = '0;
    comp_cnt   = '0;
    pad_left   = '0;
    col_idx    = '0;
    row_idx    = '0;
    image_done = 1'b0;
  endtask

  // Advance the parser by one file byte and queue the beat it produces, if any.
  task automatic parse_byte(input logic [7:0] b, input logic sof);
    word_t       pos;
    pixel_beat_t beat;
    if (sof) clear_parser();
    pos = byte_pos;
    if (byte_pos != '1) byte_pos++;
    if (image_done) return;
    beat = '0;
    if (pos < HEADER_END) begin
      if (pos >= OFFSET_POS && pos < OFFSET_POS + 4)
        pix_offset = pix_offset | (word_t'(b) << (8 * (pos - OFFSET_POS)));
      if (pos >= WIDTH_POS && pos < WIDTH_POS + 4)
        img_w = img_w | (word_t'(b) << (8 * (pos - WIDTH_POS)));
      if (pos >= HEIGHT_POS && pos < HEIGHT_POS + 4)
        img_h = img_h | (word_t'(b) << (8 * (pos - HEIGHT_POS)));
      if (pos == HEADER_END - 1) begin
        if (img_w == 0 || img_w > MAX_WIDTH || img_h == 0 || img_h > MAX_HEIGHT ||
            pix_offset < HEADER_END) begin
          image_done   = 1'b1;
          beat.hdr_err = 1'b1;
          pending_pixels.push_back(beat);
        end
      end
      return;
    end
    if (pos < pix_offset) return;
    if (pad_left != 0) begin
      pad_left--;
      return;
    end
    case (comp_cnt)
      2'd0: begin
        held_blue = b;
        comp_cnt  = 2'd1;
      end
      2'd1: begin
        held_green = b;
        comp_cnt   = 2'd2;
      end
      default: begin
        comp_cnt    = 2'd0;
        beat.red    = b;
        beat.green  = held_green;
        beat.blue   = held_blue;
        beat.row    = row_idx[11:0];
        beat.column = col_idx[11:0];
        col_idx++;
        if (col_idx >= img_w) begin
          col_idx  = '0;
          row_idx++;
          pad_left = 2'((4 - ((3 * (img_w & 3)) & 3)) & 3);
          if (row_idx >= img_h) begin
            beat.last  = 1'b1;
            image_done = 1'b1;
          end
        end
        pending_pixels.push_back(beat);
      end
    endcase
  endtask

  task automatic compare_field(input string name, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endtask

  task automatic check_pixel();
    pixel_beat_t want;
    if (pending_pixels.size() == 0) begin
      $error("pixel beat with nothing expected: row %0d column %0d error %0d",
             pix_if.pixel_row, pix_if.pixel_column, pix_if.header_error);
      mismatches++;
      return;
    end
    want = pending_pixels.pop_front();
    compare_field("red", want.red, pix_if.red);
    compare_field("green", want.green, pix_if.green);
    compare_field("blue", want.blue, pix_if.blue);
    compare_field("pixel_row", want.row, pix_if.pixel_row);
    compare_field("pixel_column", want.column, pix_if.pixel_column);
    compare_field("last_pixel", want.last, pix_if.last_pixel);
    compare_field("header_error", want.hdr_err, pix_if.header_error);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_parser();
      pending_pixels.delete();
      mismatches = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (pix_if.valid && pix_if.ready) check_pixel();
      if (byte_if.valid && byte_if.ready) parse_byte(byte_if.byte_value, byte_if.start_of_file);
      fail_count_o <= mismatches;
      pending_o    <= pending_pixels.size();
    end
  end

endmodule

// File: tb/tb.sv
// Top-level testbench for the BMP pixel stream unpacker: clock, reset, byte stimulus,
// pixel sink with random back-pressure, and the final verdict.
// Depends on bpsu_pkg, both channel interfaces, the unpacker and bpsu_stream_checker.
`timescale 1ns / 1ps

module tb;
  import bpsu_pkg::*;

  // Roughly 1300 bytes, each with its idle gaps and stalls, plus the long hold: far below this.
  localparam int unsigned CYCLE_LIMIT  = 500000;
  localparam int unsigned RANDOM_BYTES = 250;
  localparam int unsigned LONG_HOLD    = 400;
  localparam int unsigned DRAIN_CYCLES = 10;

  logic clk_i;
  logic rst_ni;

  bpsu_byte_if byte_if ();
  bpsu_pix_if  pix_if ();

  int          fail_count;
  int          pending;
  int unsigned cycle_count = 0;
  int unsigned rand_bytes;
  bit          hold_armed;
  bit          hold_done = 1'b0;
  bit          no_idle;

  bmp_pixel_stream_unpacker u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .byte_i (byte_if),
    .pix_o  (pix_if)
  );

  bpsu_stream_checker u_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_if      (byte_if),
    .pix_if       (pix_if),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog: a hung handshake or a lost beat ends the run here.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Idle length: mostly none or short, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  // Bytes in a complete file: offset, then every row with its padding.
  function automatic int unsigned bitmap_len(input int unsigned w, input int unsigned h,
                                             input int unsigned off);
    int unsigned pad;
    pad = (4 - ((3 * w) & 3)) & 3;
    return off + h * (3 * w + pad);
  endfunction

  // Offer one beat; hold it until the unpacker takes it.
  task automatic send_beat(input logic [7:0] b, input logic sof);
    int unsigned gap;
    gap = no_idle ? 0 : pick_gap();
    if (gap > 0) begin
      byte_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    byte_if.valid         <= 1'b1;
    byte_if.byte_value    <= b;
    byte_if.start_of_file <= sof;
    @(posedge clk_i);
    while (!byte_if.ready) @(posedge clk_i);
  endtask

  // Stream one file of len bytes. Everything is random except the three header
  // words, so pixel data and padding carry random content. Follow with tail
  // stray bytes, which a finished parser ignores.
  task automatic send_file(input word_t w, input word_t h, input word_t off,
                           input bit with_sof, input int unsigned len,
                           input int unsigned tail, input bit counted);
    logic [7:0]  b;
    int unsigned i;
    for (i = 0; i < len; i++) begin
      b = 8'($urandom_range(0, 255));
      if (i >= OFFSET_POS && i < OFFSET_POS + 4) b = off[8 * (i - OFFSET_POS) +: 8];
      if (i >= WIDTH_POS && i < WIDTH_POS + 4)   b = w[8 * (i - WIDTH_POS) +: 8];
      if (i >= HEIGHT_POS && i < HEIGHT_POS + 4) b = h[8 * (i - HEIGHT_POS) +: 8];
      send_beat(b, with_sof && i == 0);
      if (counted) rand_bytes++;
    end
    repeat (tail) send_beat(8'($urandom_range(0, 255)), 1'b0);
  endtask

  // Pixel sink: random ready runs and stalls, plus one long hold-off once the
  // random traffic starts, so the output register fills and input backs up.
  initial begin
    int unsigned run;
    int unsigned gap;
    pix_if.ready <= 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (hold_armed && !hold_done) begin
        pix_if.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
        hold_done = 1'b1;
      end
      run = ($urandom_range(0, 5) == 0) ? 200 : $urandom_range(1, 30);
      pix_if.ready <= 1'b1;
      repeat (run) @(posedge clk_i);
      gap = pick_gap();
      if (gap > 0) begin
        pix_if.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  end

  initial begin
    word_t       w;
    word_t       h;
    word_t       off;
    int unsigned kind;
    int unsigned n;
    rand_bytes  = 0;
    hold_armed  = 1'b0;
    no_idle     = 1'b0;
    rst_ni                <= 1'b0;
    byte_if.valid         <= 1'b0;
    byte_if.byte_value    <= 8'h00;
    byte_if.start_of_file <= 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed files.
    // First file right after reset, no start flag: byte zero by position alone.
    send_file(2, 2, HEADER_END, 1'b0, bitmap_len(2, 2, HEADER_END), 0, 1'b0);
    // Single pixel, one pad byte; then three pad bytes with a skipped gap before data.
    send_file(1, 1, HEADER_END, 1'b1, bitmap_len(1, 1, HEADER_END), 0, 1'b0);
    send_file(3, 2, 40, 1'b1, bitmap_len(3, 2, 40), 0, 1'b0);
    // No padding; stray bytes after the last pixel must stay silent.
    send_file(4, 2, 54, 1'b1, bitmap_len(4, 2, 54), 5, 1'b0);
    // Header rejects: each bound, zero, negative, and offsets below the header end.
    send_file(0, 2, HEADER_END, 1'b1, HEADER_END, 3, 1'b0);
    send_file(MAX_WIDTH + 1, 2, HEADER_END, 1'b1, HEADER_END, 3, 1'b0);
    send_file(32'h8000_0000, 2, HEADER_END, 1'b1, HEADER_END, 3, 1'b0);
    send_file(2, 0, HEADER_END, 1'b1, HEADER_END, 3, 1'b0);
    send_file(2, MAX_HEIGHT + 1, HEADER_END, 1'b1, HEADER_END, 3, 1'b0);
    send_file(2, 32'hffff_ffff, HEADER_END, 1'b1, HEADER_END, 3, 1'b0);
    send_file(2, 2, HEADER_END - 1, 1'b1, HEADER_END, 3, 1'b0);
    send_file(2, 2, 0, 1'b1, HEADER_END, 3, 1'b0);
    // Largest legal sizes pass the check; cut them short with a restart.
    send_file(MAX_WIDTH, 1, HEADER_END, 1'b1, HEADER_END + 60, 0, 1'b0);
    send_file(1, MAX_HEIGHT, HEADER_END, 1'b1, HEADER_END + 40, 0, 1'b0);
    // Offset that is never reached: header bytes and skip bytes only.
    send_file(2, 2, 32'hffff_ffff, 1'b1, 50, 0, 1'b0);

    // Random files: mostly well-formed, some rejected, truncated or pure noise.
    hold_armed = 1'b1;
    while (rand_bytes < RANDOM_BYTES) begin
      kind    = $urandom_range(0, 99);
      no_idle = ($urandom_range(0, 4) == 0);
      w   = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 24) : $urandom_range(1, 7);
      h   = $urandom_range(1, 5);
      off = ($urandom_range(0, 2) == 0) ? HEADER_END + $urandom_range(1, 24) : HEADER_END;
      if (kind < 65) begin
        send_file(w, h, off, 1'b1, bitmap_len(w, h, off),
                  ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0, 1'b1);
      end else if (kind < 80) begin
        case ($urandom_range(0, 5))
          0: w = 0;
          1: w = MAX_WIDTH + 1 + $urandom_range(0, 100);
          2: w = 32'h8000_0000 | $urandom;
          3: h = 0;
          4: h = MAX_HEIGHT + 1 + $urandom_range(0, 100);
          default: off = $urandom_range(0, HEADER_END - 1);
        endcase
        send_file(w, h, off, 1'b1, HEADER_END, $urandom_range(0, 3), 1'b1);
      end else if (kind < 90) begin
        send_file(w, h, off, 1'b1, $urandom_range(1, bitmap_len(w, h, off) - 1), 0, 1'b1);
      end else begin
        n = $urandom_range(5, 30);
        repeat (n) begin
          send_beat(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
          rand_bytes++;
        end
      end
    end

    // Drain: drop valid, wait for every predicted beat, then a few more cycles
    // to catch anything unexpected.
    byte_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// File: bmp_pixel_stream_unpacker.f
rtl/bpsu_pkg.sv
rtl/bpsu_byte_if.sv
rtl/bpsu_pix_if.sv
rtl/bmp_pixel_stream_unpacker.sv
tb/bpsu_stream_checker.sv
tb/tb.sv
